// File: rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the polygon circle contact block
// Configuration indexes, region codes, serial unit request and saturation.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int unsigned QW = 32;
	localparam int unsigned AW = 68;

	localparam logic [1:0] CFG_VERTEX_COUNT   = 2'd0;
	localparam logic [1:0] CFG_POLYGON_RADIUS = 2'd1;
	localparam logic [1:0] CFG_CIRCLE_RADIUS  = 2'd2;

	localparam logic [1:0] REG_INSIDE  = 2'd0;
	localparam logic [1:0] REG_VERTEX1 = 2'd1;
	localparam logic [1:0] REG_VERTEX2 = 2'd2;
	localparam logic [1:0] REG_FACE    = 2'd3;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
	} ds_req_t;

	function automatic logic signed [QW-1:0] sat32(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = AW'(64'sh7FFF_FFFF);
		lo = -AW'(64'sh8000_0000);
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[QW-1:0];
	endfunction

	function automatic logic signed [QW-1:0] sub_sat(input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b);
		logic signed [AW-1:0] d;
		d = AW'(a) - AW'(b);
		return sat32(d);
	endfunction

endpackage

// File: rtl/core/polygon_circle_contact_top.sv
// ----------------------------------------------------------------------------
// polygon_circle_contact_top: convex polygon against circle contact test
// A load word writes one edge store slot. A collide word runs its jobs on the
// shared multiplier (a pair of products per job, one separation job per edge),
// plus the serial square root and two divides for a vertex region hit at an offset.
// One word is processed at a time; the output register frees the input side.
// Reset sets control and configuration to defaults; the edge store is not cleared.
// ----------------------------------------------------------------------------
module polygon_circle_contact_top #(
	parameter int unsigned MAX_EDGES = 8,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// slot, local_x, local_y, body_x, body_y, body_cos, body_sin,
	// frame_x, frame_y, frame_cos, frame_sin
	input  logic [271:0]  s_tdata,
	// opcode
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// normal_x, normal_y, anchor_x, anchor_y, contact_x, contact_y
	output logic [191:0]  m_tdata,
	// hit, region
	output logic [2:0]    m_tuser,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	import pcc_pkg::*;

	localparam int unsigned IW = $clog2(MAX_EDGES);
	localparam int unsigned NW = $clog2(MAX_EDGES + 1);

	typedef enum logic [14:0] {
		S_IDLE    = 15'h0001,
		S_M0      = 15'h0002,
		S_M1      = 15'h0004,
		S_M2      = 15'h0008,
		S_FETCH1  = 15'h0010,
		S_FETCH2  = 15'h0020,
		S_SQRT_GO = 15'h0040,
		S_SQRT    = 15'h0080,
		S_DIVX_GO = 15'h0100,
		S_DIVX    = 15'h0200,
		S_DIVY_GO = 15'h0400,
		S_DIVY    = 15'h0800,
		S_DONE    = 15'h1000,
		S_SPARE1  = 15'h2000,
		S_SPARE2  = 15'h4000
	} state_t;

	typedef enum logic [3:0] {
		J_CX, J_CY, J_PX, J_PY, J_R2, J_SEP, J_U1, J_U2, J_D2, J_FACE
	} job_t;

	state_t state_q;
	job_t   job_q;

	logic [3:0]  vcount_q;
	logic [30:0] prad_q;
	logic [30:0] crad_q;

	logic signed [31:0] lx_q, ly_q, bx_q, by_q, fx_q, fy_q;
	logic signed [17:0] bc_q, bs_q, fc_q, fs_q;
	logic signed [31:0] cx_q, cy_q, px_q, py_q;
	logic signed [AW-1:0] r2_q, sep_q, u1_q, t0_q;
	logic signed [65:0] raw0_q;
	logic [IW-1:0] idx_q, best_q;
	logic signed [31:0] v1x_q, v1y_q, v2x_q, v2y_q, nbx_q, nby_q, mx_q, my_q;
	logic signed [31:0] ddx_q, ddy_q;
	logic [63:0] sq_q;
	logic [31:0] len_q;
	logic        hit_q;
	logic [1:0]  region_q;
	logic signed [31:0] nrx_q, nry_q, anx_q, any_q;

	logic         m_tvalid_q;
	logic [191:0] m_tdata_q;
	logic [2:0]   m_tuser_q;

	logic signed [31:0] rvx, rvy, rnx, rny;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [AW-1:0] res, addend, t1;
	logic signed [65:0] raw;
	logic [31:0] rad_sum;
	logic [30:0] rad;
	logic [NW-1:0] n_edges;
	logic [NW-1:0] i2_sum;
	logic [IW-1:0] i2;
	logic signed [32:0] dx, dy, msx, msy;
	logic in_acc, cfg_acc, ph;
	logic s_better;
	logic [IW-1:0] best_n;
	logic signed [AW-1:0] rad_w;
	ds_req_t ds_req;
	logic [63:0] ds_num, ds_res;
	logic ds_done;
	logic [31:0] dmag;
	logic signed [31:0] qsat;
	logic ld_we;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	assign rad_sum = {1'b0, prad_q} + {1'b0, crad_q};
	assign rad     = rad_sum[31] ? 31'h7FFF_FFFF : rad_sum[30:0];
	assign rad_w   = AW'({1'b0, rad});

	always_comb begin
		if (vcount_q < 4'd3) begin
			n_edges = NW'(3);
		end else if (32'(vcount_q) > MAX_EDGES) begin
			n_edges = NW'(MAX_EDGES);
		end else begin
			n_edges = NW'(vcount_q);
		end
	end

	assign i2_sum = NW'(best_q) + NW'(1);
	assign i2     = (i2_sum < n_edges) ? i2_sum[IW-1:0] : '0;

	assign dx = 33'(cx_q) - 33'(fx_q);
	assign dy = 33'(cy_q) - 33'(fy_q);
	assign msx = 33'(v1x_q) + 33'(rvx);
	assign msy = 33'(v1y_q) + 33'(rvy);

	assign ld_we = in_acc && !s_tuser && (32'(s_tdata[2:0]) < MAX_EDGES);

	pcc_edge_regs #(.MAX_EDGES(MAX_EDGES), .IW(IW)) u_edges (
		.clk   (clk),
		.we    (ld_we),
		.waddr (IW'(s_tdata[2:0])),
		.wvx   (s_tdata[34:3]),
		.wvy   (s_tdata[66:35]),
		.wnx   (s_tdata[98:67]),
		.wny   (s_tdata[130:99]),
		.raddr (idx_q),
		.rvx   (rvx),
		.rvy   (rvy),
		.rnx   (rnx),
		.rny   (rny)
	);

	assign ph = (state_q == S_M1);

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		addend = '0;
		case (job_q)
			J_CX: begin
				mul_a  = ph ? 33'(bs_q) : 33'(bc_q);
				mul_b  = ph ? 33'(ly_q) : 33'(lx_q);
				addend = AW'(bx_q);
			end
			J_CY: begin
				mul_a  = ph ? 33'(bc_q) : 33'(bs_q);
				mul_b  = ph ? 33'(ly_q) : 33'(lx_q);
				addend = AW'(by_q);
			end
			J_PX: begin
				mul_a = ph ? 33'(fs_q) : 33'(fc_q);
				mul_b = ph ? dy : dx;
			end
			J_PY: begin
				mul_a = ph ? 33'(fs_q) : 33'(fc_q);
				mul_b = ph ? dx : dy;
			end
			J_R2: begin
				mul_a = ph ? 33'sd0 : 33'({2'b00, rad});
				mul_b = ph ? 33'sd0 : 33'({2'b00, rad});
			end
			J_SEP: begin
				mul_a = ph ? 33'(rny) : 33'(rnx);
				mul_b = ph ? 33'(sub_sat(py_q, rvy)) : 33'(sub_sat(px_q, rvx));
			end
			J_U1: begin
				mul_a = ph ? 33'(sub_sat(py_q, v1y_q)) : 33'(sub_sat(px_q, v1x_q));
				mul_b = ph ? 33'(sub_sat(v2y_q, v1y_q)) : 33'(sub_sat(v2x_q, v1x_q));
			end
			J_U2: begin
				mul_a = ph ? 33'(sub_sat(py_q, v2y_q)) : 33'(sub_sat(px_q, v2x_q));
				mul_b = ph ? 33'(sub_sat(v1y_q, v2y_q)) : 33'(sub_sat(v1x_q, v2x_q));
			end
			J_D2: begin
				mul_a = ph ? 33'(ddy_q) : 33'(ddx_q);
				mul_b = ph ? 33'(ddy_q) : 33'(ddx_q);
			end
			J_FACE: begin
				mul_a = ph ? 33'(sub_sat(py_q, my_q)) : 33'(sub_sat(px_q, mx_q));
				mul_b = ph ? 33'(nby_q) : 33'(nbx_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pcc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign t1 = AW'(mul_p >>> FRAC_BITS);
	assign raw = mul_p + raw0_q;

	always_comb begin
		if (job_q == J_CX || job_q == J_PY) begin
			res = t0_q - t1 + addend;
		end else begin
			res = t0_q + t1 + addend;
		end
	end

	assign s_better = (idx_q == '0) || (res > sep_q);
	assign best_n   = s_better ? idx_q : best_q;

	always_comb begin
		ds_req.start     = (state_q == S_SQRT_GO) || (state_q == S_DIVX_GO) ||
			(state_q == S_DIVY_GO);
		ds_req.sqrt_mode = (state_q == S_SQRT_GO);
		if (state_q == S_DIVY_GO) begin
			dmag = ddy_q[31] ? (~ddy_q + 32'd1) : ddy_q;
		end else begin
			dmag = ddx_q[31] ? (~ddx_q + 32'd1) : ddx_q;
		end
		ds_num = (state_q == S_SQRT_GO) ? sq_q : (64'(dmag) << FRAC_BITS);
	end

	pcc_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ds_req),
		.num    (ds_num),
		.den    (len_q),
		.done   (ds_done),
		.result (ds_res)
	);

	always_comb begin
		logic neg;
		neg = (state_q == S_DIVY) ? ddy_q[31] : ddx_q[31];
		if (neg) begin
			qsat = (ds_res > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-ds_res);
		end else begin
			qsat = (ds_res > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : ds_res[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 4'd3;
			prad_q   <= '0;
			crad_q   <= 31'd65536;
		end else if (cfg_acc) begin
			unique case (cfg_index)
				CFG_VERTEX_COUNT:   vcount_q <= cfg_data[3:0];
				CFG_POLYGON_RADIUS: prad_q   <= cfg_data[30:0];
				CFG_CIRCLE_RADIUS:  crad_q   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			job_q      <= J_CX;
			m_tvalid_q <= 1'b0;
			hit_q      <= 1'b0;
			idx_q      <= '0;
			best_q     <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && s_tuser) begin
						hit_q   <= 1'b0;
						job_q   <= J_CX;
						state_q <= S_M0;
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: begin
					case (job_q)
						J_CX: begin
							job_q   <= J_CY;
							state_q <= S_M0;
						end
						J_CY: begin
							job_q   <= J_PX;
							state_q <= S_M0;
						end
						J_PX: begin
							job_q   <= J_PY;
							state_q <= S_M0;
						end
						J_PY: begin
							job_q   <= J_R2;
							state_q <= S_M0;
						end
						J_R2: begin
							idx_q   <= '0;
							job_q   <= J_SEP;
							state_q <= S_M0;
						end
						J_SEP: begin
							if (res > rad_w) begin
								state_q <= S_DONE;
							end else begin
								best_q <= best_n;
								if (NW'(idx_q) + NW'(1) == n_edges) begin
									idx_q   <= best_n;
									state_q <= S_FETCH1;
								end else begin
									idx_q   <= idx_q + IW'(1);
									state_q <= S_M0;
								end
							end
						end
						J_U1: begin
							job_q   <= J_U2;
							state_q <= S_M0;
						end
						J_U2: begin
							state_q <= S_M0;
							if (u1_q <= 0) begin
								region_q <= REG_VERTEX1;
								job_q    <= J_D2;
							end else if (res <= 0) begin
								region_q <= REG_VERTEX2;
								job_q    <= J_D2;
							end else begin
								region_q <= REG_FACE;
								job_q    <= J_FACE;
							end
						end
						J_D2: begin
							if (res > r2_q) begin
								state_q <= S_DONE;
							end else begin
								hit_q <= 1'b1;
								state_q <= (raw == 66'sd0) ? S_DONE : S_SQRT_GO;
							end
						end
						J_FACE: begin
							hit_q   <= (res <= rad_w);
							state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_FETCH1: begin
					idx_q   <= i2;
					state_q <= S_FETCH2;
				end
				S_FETCH2: begin
					if (sep_q <= 0) begin
						hit_q    <= 1'b1;
						region_q <= REG_INSIDE;
						state_q  <= S_DONE;
					end else begin
						job_q   <= J_U1;
						state_q <= S_M0;
					end
				end
				S_SQRT_GO: state_q <= S_SQRT;
				S_SQRT:    if (ds_done) state_q <= S_DIVX_GO;
				S_DIVX_GO: state_q <= S_DIVX;
				S_DIVX:    if (ds_done) state_q <= S_DIVY_GO;
				S_DIVY_GO: state_q <= S_DIVY;
				S_DIVY:    if (ds_done) state_q <= S_DONE;
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser) begin
			lx_q <= s_tdata[34:3];
			ly_q <= s_tdata[66:35];
			bx_q <= s_tdata[98:67];
			by_q <= s_tdata[130:99];
			bc_q <= s_tdata[148:131];
			bs_q <= s_tdata[166:149];
			fx_q <= s_tdata[198:167];
			fy_q <= s_tdata[230:199];
			fc_q <= s_tdata[248:231];
			fs_q <= s_tdata[266:249];
		end
		if (state_q == S_M1) begin
			t0_q   <= t1;
			raw0_q <= mul_p;
		end
		if (state_q == S_M2) begin
			case (job_q)
				J_CX:  cx_q <= sat32(res);
				J_CY:  cy_q <= sat32(res);
				J_PX:  px_q <= sat32(res);
				J_PY:  py_q <= sat32(res);
				J_R2:  r2_q <= res;
				J_SEP: if (s_better) sep_q <= res;
				J_U1:  u1_q <= res;
				J_U2: begin
					if (u1_q <= 0) begin
						ddx_q <= sub_sat(px_q, v1x_q);
						ddy_q <= sub_sat(py_q, v1y_q);
						anx_q <= v1x_q;
						any_q <= v1y_q;
					end else begin
						ddx_q <= sub_sat(px_q, v2x_q);
						ddy_q <= sub_sat(py_q, v2y_q);
						anx_q <= v2x_q;
						any_q <= v2y_q;
					end
				end
				J_D2: begin
					sq_q  <= raw[63:0];
					nrx_q <= '0;
					nry_q <= '0;
				end
				J_FACE: begin
					nrx_q <= nbx_q;
					nry_q <= nby_q;
					anx_q <= mx_q;
					any_q <= my_q;
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_FETCH1) begin
			v1x_q <= rvx;
			v1y_q <= rvy;
			nbx_q <= rnx;
			nby_q <= rny;
		end
		if (state_q == S_FETCH2) begin
			v2x_q <= rvx;
			v2y_q <= rvy;
			mx_q  <= 32'(msx >>> 1);
			my_q  <= 32'(msy >>> 1);
			nrx_q <= nbx_q;
			nry_q <= nby_q;
			anx_q <= 32'(msx >>> 1);
			any_q <= 32'(msy >>> 1);
		end
		if (state_q == S_SQRT && ds_done) begin
			len_q <= ds_res[31:0];
		end
		if (state_q == S_DIVX && ds_done) begin
			nrx_q <= qsat;
		end
		if (state_q == S_DIVY && ds_done) begin
			nry_q <= qsat;
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tuser_q <= hit_q ? {region_q, 1'b1} : 3'b000;
			m_tdata_q <= {ly_q, lx_q,
				hit_q ? any_q : 32'sd0, hit_q ? anx_q : 32'sd0,
				hit_q ? nry_q : 32'sd0, hit_q ? nrx_q : 32'sd0};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/core/pcc_mul.sv
// ----------------------------------------------------------------------------
// pcc_mul: shared signed multiplier
// One 33 by 33 bit signed product per cycle with a registered result.
// ----------------------------------------------------------------------------
module pcc_mul (
	input  logic                clk,
	input  logic signed [32:0]  a,
	input  logic signed [32:0]  b,
	output logic signed [65:0]  p
);

	logic signed [65:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 66'(a) * 66'(b);
	end

	assign p = p_q;

endmodule

// File: rtl/core/pcc_divsqrt.sv
// ----------------------------------------------------------------------------
// pcc_divsqrt: serial square root and divider
// Floor square root of a 64 bit word two bits a cycle, or restoring
// division of a 64 bit word by a 32 bit word one bit a cycle.
// ----------------------------------------------------------------------------
module pcc_divsqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  pcc_pkg::ds_req_t  req,
	input  logic [63:0]       num,
	input  logic [31:0]       den,
	output logic              done,
	output logic [63:0]       result
);

	import pcc_pkg::*;

	logic        run_q;
	logic        done_q;
	logic        mode_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [31:0] den_q;
	logic [35:0] rem_q;
	logic [63:0] res_q;

	logic [35:0] sq_rem2;
	logic [35:0] sq_trial;
	logic [35:0] dv_rem2;
	logic [35:0] dv_den;

	assign sq_rem2  = {rem_q[33:0], acc_q[63:62]};
	assign sq_trial = {2'b00, res_q[31:0], 2'b01};
	assign dv_rem2  = {3'b000, rem_q[31:0], acc_q[63]};
	assign dv_den   = {4'b0000, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.sqrt_mode ? 6'd31 : 6'd63;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.sqrt_mode;
			acc_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			res_q  <= '0;
		end else if (run_q) begin
			if (mode_q) begin
				acc_q <= {acc_q[61:0], 2'b00};
				if (sq_rem2 >= sq_trial) begin
					rem_q <= sq_rem2 - sq_trial;
					res_q <= {res_q[62:0], 1'b1};
				end else begin
					rem_q <= sq_rem2;
					res_q <= {res_q[62:0], 1'b0};
				end
			end else begin
				acc_q <= {acc_q[62:0], 1'b0};
				if (dv_rem2 >= dv_den) begin
					rem_q <= dv_rem2 - dv_den;
					res_q <= {res_q[62:0], 1'b1};
				end else begin
					rem_q <= dv_rem2;
					res_q <= {res_q[62:0], 1'b0};
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: rtl/core/pcc_edge_regs.sv
// ----------------------------------------------------------------------------
// pcc_edge_regs: polygon edge store
// Vertex and outward normal of each edge, one write and one read port.
// ----------------------------------------------------------------------------
module pcc_edge_regs #(
	parameter int unsigned MAX_EDGES = 8,
	parameter int unsigned IW = $clog2(MAX_EDGES)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IW-1:0]         waddr,
	input  logic signed [31:0]    wvx,
	input  logic signed [31:0]    wvy,
	input  logic signed [31:0]    wnx,
	input  logic signed [31:0]    wny,
	input  logic [IW-1:0]         raddr,
	output logic signed [31:0]    rvx,
	output logic signed [31:0]    rvy,
	output logic signed [31:0]    rnx,
	output logic signed [31:0]    rny
);

	logic signed [31:0] vx_q [MAX_EDGES];
	logic signed [31:0] vy_q [MAX_EDGES];
	logic signed [31:0] nx_q [MAX_EDGES];
	logic signed [31:0] ny_q [MAX_EDGES];

	always_ff @(posedge clk) begin
		if (we) begin
			vx_q[waddr] <= wvx;
			vy_q[waddr] <= wvy;
			nx_q[waddr] <= wnx;
			ny_q[waddr] <= wny;
		end
	end

	assign rvx = vx_q[raddr];
	assign rvy = vy_q[raddr];
	assign rnx = nx_q[raddr];
	assign rny = ny_q[raddr];

endmodule

// File: dv/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker: contact prediction and result comparison
// Watches the input, configuration and result channels of the polygon circle
// contact block. It keeps its own edge store and registers, works out the
// contact for each collide word, and compares every result word, field by
// field, against the oldest prediction that is still waiting.
// ----------------------------------------------------------------------------
module pcc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [271:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic [2:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pcc_pkg::*;

	localparam int EDGES = 8;
	localparam int FB = 16;
	localparam longint S32MAX = 64'sd2147483647;
	localparam longint S32MIN = -64'sd2147483648;

	typedef struct packed {
		logic        hit;
		logic [1:0]  region;
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] cx;
		logic [31:0] cy;
	} contact_t;

	longint vert_x [EDGES];
	longint vert_y [EDGES];
	longint norm_x [EDGES];
	longint norm_y [EDGES];
	int unsigned edge_cfg;
	longint poly_rad;
	longint circ_rad;
	contact_t contacts_due[$];

	assign pending = contacts_due.size();

	function automatic longint qfl(longint v);
		return v >>> FB;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > S32MAX) begin
			return S32MAX;
		end else if (v < S32MIN) begin
			return S32MIN;
		end
		return v;
	endfunction

	function automatic longint qdot(longint ax, longint ay, longint bx, longint by);
		return qfl(ax * bx) + qfl(ay * by);
	endfunction

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) begin
			b = b >> 2;
		end
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic void unit_vec(longint dx, longint dy, output longint ux,
		output longint uy);
		longint unsigned sq;
		longint len;
		sq = longint'(dx * dx) + longint'(dy * dy);
		if (sq == 0) begin
			ux = 0;
			uy = 0;
		end else begin
			len = floor_sqrt(sq);
			if (len < 1) begin
				len = 1;
			end
			ux = clamp32((dx * 65536) / len);
			uy = clamp32((dy * 65536) / len);
		end
	endfunction

	function automatic contact_t predict_contact(logic [271:0] d);
		contact_t c;
		logic signed [31:0] f32 [8];
		logic signed [17:0] f18 [4];
		longint lx, ly, bx, by, bc, bs, fx, fy, fc, fs;
		longint cxw, cyw, dx, dy, px, py, radius, r2, s, sep;
		longint v1x, v1y, v2x, v2y, mx, my, u1, u2, nx, ny, ax, ay;
		int n, best, i2;
		logic miss;
		logic hit;
		logic [1:0] region;
		f32[0] = d[34:3];
		f32[1] = d[66:35];
		f32[2] = d[98:67];
		f32[3] = d[130:99];
		f18[0] = d[148:131];
		f18[1] = d[166:149];
		f32[4] = d[198:167];
		f32[5] = d[230:199];
		f18[2] = d[248:231];
		f18[3] = d[266:249];
		lx = f32[0]; ly = f32[1]; bx = f32[2]; by = f32[3];
		bc = f18[0]; bs = f18[1];
		fx = f32[4]; fy = f32[5];
		fc = f18[2]; fs = f18[3];
		nx = 0; ny = 0; ax = 0; ay = 0; sep = 0; best = 0;
		hit = 0; region = REG_INSIDE; miss = 0;

		cxw = clamp32(qfl(bc * lx) - qfl(bs * ly) + bx);
		cyw = clamp32(qfl(bs * lx) + qfl(bc * ly) + by);
		dx = cxw - fx;
		dy = cyw - fy;
		px = clamp32(qfl(fc * dx) + qfl(fs * dy));
		py = clamp32(qfl(fc * dy) - qfl(fs * dx));

		radius = poly_rad + circ_rad;
		if (radius > S32MAX) begin
			radius = S32MAX;
		end
		r2 = qfl(radius * radius);

		n = edge_cfg;
		if (n < 3) begin
			n = 3;
		end
		if (n > EDGES) begin
			n = EDGES;
		end

		for (int i = 0; i < n; i++) begin
			s = qdot(norm_x[i], norm_y[i], clamp32(px - vert_x[i]), clamp32(py - vert_y[i]));
			if (s > radius) begin
				miss = 1;
				break;
			end
			if (i == 0 || s > sep) begin
				sep = s;
				best = i;
			end
		end

		if (!miss) begin
			i2 = (best + 1 < n) ? best + 1 : 0;
			v1x = vert_x[best]; v1y = vert_y[best];
			v2x = vert_x[i2]; v2y = vert_y[i2];
			mx = (v1x + v2x) >>> 1;
			my = (v1y + v2y) >>> 1;
			if (sep <= 0) begin
				hit = 1;
				region = REG_INSIDE;
				nx = norm_x[best]; ny = norm_y[best];
				ax = mx; ay = my;
			end else begin
				u1 = qdot(clamp32(px - v1x), clamp32(py - v1y),
					clamp32(v2x - v1x), clamp32(v2y - v1y));
				u2 = qdot(clamp32(px - v2x), clamp32(py - v2y),
					clamp32(v1x - v2x), clamp32(v1y - v2y));
				if (u1 <= 0) begin
					dx = clamp32(px - v1x); dy = clamp32(py - v1y);
					if (qdot(dx, dy, dx, dy) <= r2) begin
						hit = 1;
						region = REG_VERTEX1;
						unit_vec(dx, dy, nx, ny);
						ax = v1x; ay = v1y;
					end
				end else if (u2 <= 0) begin
					dx = clamp32(px - v2x); dy = clamp32(py - v2y);
					if (qdot(dx, dy, dx, dy) <= r2) begin
						hit = 1;
						region = REG_VERTEX2;
						unit_vec(dx, dy, nx, ny);
						ax = v2x; ay = v2y;
					end
				end else begin
					s = qdot(clamp32(px - mx), clamp32(py - my), norm_x[best], norm_y[best]);
					if (s <= radius) begin
						hit = 1;
						region = REG_FACE;
						nx = norm_x[best]; ny = norm_y[best];
						ax = mx; ay = my;
					end
				end
			end
		end

		if (!hit) begin
			region = REG_INSIDE;
			nx = 0; ny = 0; ax = 0; ay = 0;
		end
		c.hit = hit;
		c.region = region;
		c.nx = nx[31:0];
		c.ny = ny[31:0];
		c.ax = ax[31:0];
		c.ay = ay[31:0];
		c.cx = lx[31:0];
		c.cy = ly[31:0];
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		contact_t got;
		contact_t want;
		logic [2:0] slot;
		if (!arst_n) begin
			edge_cfg <= 3;
			poly_rad <= 0;
			circ_rad <= 65536;
			contacts_due.delete();
			errors <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_VERTEX_COUNT: begin
						edge_cfg <= cfg_data[3:0];
					end
					CFG_POLYGON_RADIUS: begin
						poly_rad <= longint'(cfg_data[30:0]);
					end
					CFG_CIRCLE_RADIUS: begin
						circ_rad <= longint'(cfg_data[30:0]);
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == 1'b0) begin
					slot = s_tdata[2:0];
					vert_x[slot] = longint'($signed(s_tdata[34:3]));
					vert_y[slot] = longint'($signed(s_tdata[66:35]));
					norm_x[slot] = longint'($signed(s_tdata[98:67]));
					norm_y[slot] = longint'($signed(s_tdata[130:99]));
				end else begin
					contacts_due.push_back(predict_contact(s_tdata));
				end
			end
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser[0];
				got.region = m_tuser[2:1];
				got.nx = m_tdata[31:0];
				got.ny = m_tdata[63:32];
				got.ax = m_tdata[95:64];
				got.ay = m_tdata[127:96];
				got.cx = m_tdata[159:128];
				got.cy = m_tdata[191:160];
				if (contacts_due.size() == 0) begin
					if (errors < 10) begin
						$display("%0t: result word with no collide pending", $realtime);
					end
					errors <= errors + 1;
				end else begin
					want = contacts_due.pop_front();
					if (got != want) begin
						if (errors < 10) begin
							$display("%0t: mismatch hit %0d/%0d region %0d/%0d", $realtime,
								want.hit, got.hit, want.region, got.region);
							$display("  normal exp %h %h got %h %h", want.nx, want.ny,
								got.nx, got.ny);
							$display("  anchor exp %h %h got %h %h", want.ax, want.ay,
								got.ax, got.ay);
							$display("  contact exp %h %h got %h %h", want.cx, want.cy,
								got.cx, got.cy);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: polygon circle contact regression
// Loads convex polygons, runs directed and random collide words through the
// block under several radius and edge count settings with random stalls on
// both sides, and lets the checker compare every result word.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcc_pkg::*;

	localparam int LIMIT = 2000000;
	localparam int SETTLE = 300;
	localparam real TWO_PI = 6.283185307179586;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [271:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           errors;
	int           pending;
	int           idle_pct;
	int           cycles;

	polygon_circle_contact_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pcc_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_pct);
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [271:0] pack_word(logic [2:0] slot, logic [31:0] lx,
		logic [31:0] ly, logic [31:0] bx, logic [31:0] by, logic [17:0] bc,
		logic [17:0] bs, logic [31:0] fx, logic [31:0] fy, logic [17:0] fc,
		logic [17:0] fs);
		return {5'b0, fs, fc, fy, fx, bs, bc, by, bx, ly, lx, slot};
	endfunction

	function automatic logic [17:0] rand_trig();
		return 18'($signed($urandom_range(131072)) - 65536);
	endfunction

	function automatic logic [31:0] rand_span(int span);
		return 32'($signed($urandom_range(2 * span)) - span);
	endfunction

	task automatic send_word(input logic op, input logic [271:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		s_tvalid <= 0;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_polygon(input int n, input real rad);
		real ang;
		real nang;
		for (int k = 0; k < 8; k++) begin
			if (k < n) begin
				ang = TWO_PI * k / n;
				nang = ang + TWO_PI / (2 * n);
				send_word(1'b0, pack_word(3'(k),
					32'($rtoi(rad * $cos(ang) * 65536.0)), 32'($rtoi(rad * $sin(ang) * 65536.0)),
					32'($rtoi($cos(nang) * 65536.0)), 32'($rtoi($sin(nang) * 65536.0)),
					rand_trig(), rand_trig(), $urandom, $urandom, rand_trig(), rand_trig()));
			end else begin
				send_word(1'b0, pack_word(3'(k), $urandom, $urandom, $urandom, $urandom,
					rand_trig(), rand_trig(), $urandom, $urandom, rand_trig(), rand_trig()));
			end
		end
	endtask

	task automatic collide_random();
		real ba;
		real fa;
		ba = TWO_PI * $urandom_range(9999) / 10000.0;
		fa = TWO_PI * $urandom_range(9999) / 10000.0;
		if ($urandom_range(99) < 85) begin
			send_word(1'b1, pack_word(3'($urandom), rand_span(200000), rand_span(200000),
				rand_span(260000), rand_span(260000),
				18'($rtoi($cos(ba) * 65536.0)), 18'($rtoi($sin(ba) * 65536.0)),
				rand_span(130000), rand_span(130000),
				18'($rtoi($cos(fa) * 65536.0)), 18'($rtoi($sin(fa) * 65536.0))));
		end else begin
			send_word(1'b1, pack_word(3'($urandom), $urandom, $urandom, $urandom, $urandom,
				rand_trig(), rand_trig(), $urandom, $urandom, rand_trig(), rand_trig()));
		end
	endtask

	initial begin
		int vc [8];
		logic [30:0] pr [8];
		logic [30:0] cr [8];
		int n;
		vc = '{3, 4, 0, 8, 15, 6, 2, 5};
		pr = '{31'd0, 31'd0, 31'h8000, 31'd0, 31'h7FFF_FFFF, 31'd0, 31'd20000, 31'd6000};
		cr = '{31'd65536, 31'd32768, 31'h10000, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
			31'd40000, 31'd90000};
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = 0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_index = CFG_VERTEX_COUNT;
		cfg_data = '0;
		idle_pct = 17;
		cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int p = 0; p < 8; p++) begin
			idle_pct = (p == 3) ? 0 : 17;
			write_reg(CFG_VERTEX_COUNT, {$urandom_range(1) ? 28'hFFFFFFF : 28'h0, 4'(vc[p])});
			write_reg(CFG_POLYGON_RADIUS, {1'($urandom), pr[p]});
			write_reg(CFG_CIRCLE_RADIUS, {1'($urandom), cr[p]});
			n = (vc[p] < 3) ? 3 : ((vc[p] > 8) ? 8 : vc[p]);
			load_polygon(n, 1.0 + $urandom_range(200) / 100.0);
			if (p == 0) begin
				send_word(1'b1, pack_word(3'd0, 32'd0, 32'd0, 32'd0, 32'd0, 18'sd65536, 18'd0,
					32'd0, 32'd0, 18'sd65536, 18'd0));
				send_word(1'b1, pack_word(3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, 18'sd65536, 18'sd65536, 32'h8000_0000, 32'h8000_0000,
					18'sd65536, 18'sd65536));
				send_word(1'b1, pack_word(3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, -18'sd65536, -18'sd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					-18'sd65536, -18'sd65536));
				send_word(1'b1, pack_word(3'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, -18'sd65536,
					18'd0, 32'h0, 32'h0, 18'd0, -18'sd65536));
				for (int k = 0; k < 12; k++) begin
					send_word(1'b1, pack_word(3'd0, rand_span(20000), rand_span(20000),
						32'($signed(k * 30000 - 180000)), 32'($signed(90000 - k * 15000)),
						18'sd65536, 18'd0, 32'd0, 32'd0, 18'sd65536, 18'd0));
				end
			end
			for (int k = 0; k < 165; k++) begin
				collide_random();
			end
			drain();
		end

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
